/* hw/rtl/pwm_width_arm_motor_control_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the arm motor controller
// Shared property wrappers, clocked on the rising edge, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PWM_WIDTH_ARM_MOTOR_CONTROL_MACROS_SVH
`define PWM_WIDTH_ARM_MOTOR_CONTROL_MACROS_SVH

// same-cycle implication
`define PWAMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define PWAMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/pwamc_pkg.sv */
// ----------------------------------------------------------------------------
// pwamc_pkg
// Types and constants of the PWM-commanded arm motor controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pwamc_pkg;

	localparam int TIMER_BITS = 16;
	localparam int REG_W      = 16;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HIGH_THR  = 3'd0,
		CFG_LOW_THR   = 3'd1,
		CFG_POS_MIN   = 3'd2,
		CFG_POS_MAX   = 3'd3,
		CFG_SPEED     = 3'd4
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MOT_STOP = 2'd0,
		MOT_UP   = 2'd1,
		MOT_DOWN = 2'd2
	} motion_t;

	localparam logic [REG_W-1:0] HIGH_THR_RST = 16'd40000;
	localparam logic [REG_W-1:0] LOW_THR_RST  = 16'd20000;
	localparam logic [REG_W-1:0] POS_MIN_RST  = 16'd0;
	localparam logic [REG_W-1:0] POS_MAX_RST  = 16'd1000;
	localparam logic [REG_W-1:0] SPEED_RST    = 16'd32768;

endpackage

`default_nettype wire

/* hw/rtl/pwm_width_arm_motor_control.sv */
// ----------------------------------------------------------------------------
// pwm_width_arm_motor_control
// Measures the high time of a command PWM and drives an arm motor up, down
// or to a stop, tracking a bounded position counter.
//
// Usage:
//   Input channel (in_valid/in_ready): one item per poll, the sampled PWM
//   level and the free-running timer count. Output channel
//   (out_valid/out_ready): one result item per input item, in order.
//   Config channel (cfg_valid/cfg_ready): register index and 16-bit data,
//   always ready; write only while the block holds no item.
//   Flow: an item taken into the input register has its result registered
//   once the output register is free. Throughput: one item per cycle while
//   out_ready is high; the poll state (stamps, motion, position) updates in
//   one pass between the input register and the result register.
//   Reset: registers return to their defaults, stamps and position clear,
//   motion is stop, no item is held.
//   Stall: while out_ready is low the result is held; the input register
//   still takes one item, after which in_ready drops until the stall ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "pwm_width_arm_motor_control_macros.svh"

module pwm_width_arm_motor_control
	import pwamc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [REG_W-1:0]      cfg_data,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  pwm_level,
	input  wire logic [TIMER_BITS-1:0] timer_value,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [REG_W-1:0]           drive_duty,
	output logic                       direction,
	output logic [1:0]                 motion_state,
	output logic [TIMER_BITS-1:0]      pulse_high_time,
	output logic [REG_W-1:0]           arm_position
);

	// config registers
	logic [REG_W-1:0] high_thr_q, low_thr_q, pos_min_q, pos_max_q, speed_q;

	// poll state
	logic [TIMER_BITS-1:0] rise_stamp_q, fall_stamp_q, high_dur_q;
	logic [TIMER_BITS-1:0] rise_copy_q, fall_copy_q;
	motion_t               motion_q;
	logic                  go_q;
	logic [REG_W-1:0]      position_q;
	logic                  direction_q;

	// input stage
	logic                  valid_s1;
	logic                  level_s1;
	logic [TIMER_BITS-1:0] timer_s1;

	// result stage
	logic                  valid_s2;
	logic [REG_W-1:0]      duty_s2;
	logic                  dir_s2;
	motion_t               motion_s2;
	logic [TIMER_BITS-1:0] high_s2;
	logic [REG_W-1:0]      pos_s2;

	logic adv;

	assign adv       = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	// next-state logic of one poll
	logic [TIMER_BITS-1:0] rise_n, fall_n, high_n, rise_copy_n, fall_copy_n;
	logic                  go_a, go_n;
	motion_t               motion_a, motion_n;
	logic                  dir_n;
	logic [REG_W-1:0]      pos_n, duty_n;

	always_comb begin
		rise_n      = rise_stamp_q;
		fall_n      = fall_stamp_q;
		high_n      = high_dur_q;
		rise_copy_n = rise_copy_q;
		fall_copy_n = fall_copy_q;
		if (level_s1 && fall_stamp_q != fall_copy_q) begin
			fall_copy_n = fall_stamp_q;
			rise_n      = timer_s1;
		end else if (!level_s1 && rise_stamp_q != rise_copy_q) begin
			rise_copy_n = rise_stamp_q;
			fall_n      = timer_s1;
			if (rise_stamp_q < timer_s1) begin
				high_n = timer_s1 - rise_stamp_q;
			end
		end
		go_a = go_q || (high_n != '0);

		motion_a = motion_q;
		dir_n    = direction_q;
		if (go_a) begin
			if (motion_q != MOT_UP && high_n > high_thr_q && position_q > pos_min_q) begin
				motion_a = MOT_UP;
				dir_n    = 1'b1;
			end else if (motion_q != MOT_DOWN && high_n < low_thr_q
					&& position_q < pos_max_q) begin
				motion_a = MOT_DOWN;
				dir_n    = 1'b0;
			end else if (high_n < high_thr_q && high_n > low_thr_q) begin
				motion_a = MOT_STOP;
			end
		end

		motion_n = motion_a;
		go_n     = go_a;
		pos_n    = position_q;
		duty_n   = '0;
		if (motion_a != MOT_STOP) begin
			duty_n = speed_q;
			if (motion_a == MOT_DOWN && position_q < pos_max_q) begin
				pos_n = position_q + 1'b1;
			end else if (motion_a == MOT_UP && position_q > pos_min_q) begin
				pos_n = position_q - 1'b1;
			end else begin
				duty_n   = '0;
				motion_n = MOT_STOP;
				go_n     = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= HIGH_THR_RST;
			low_thr_q  <= LOW_THR_RST;
			pos_min_q  <= POS_MIN_RST;
			pos_max_q  <= POS_MAX_RST;
			speed_q    <= SPEED_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_HIGH_THR: high_thr_q <= cfg_data;
				CFG_LOW_THR:  low_thr_q  <= cfg_data;
				CFG_POS_MIN:  pos_min_q  <= cfg_data;
				CFG_POS_MAX:  pos_max_q  <= cfg_data;
				CFG_SPEED:    speed_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rise_stamp_q <= '0;
			fall_stamp_q <= '0;
			high_dur_q   <= '0;
			rise_copy_q  <= TIMER_BITS'(1);
			fall_copy_q  <= TIMER_BITS'(1);
			motion_q     <= MOT_STOP;
			go_q         <= 1'b0;
			position_q   <= '0;
			direction_q  <= 1'b0;
		end else if (adv) begin
			rise_stamp_q <= rise_n;
			fall_stamp_q <= fall_n;
			high_dur_q   <= high_n;
			rise_copy_q  <= rise_copy_n;
			fall_copy_q  <= fall_copy_n;
			motion_q     <= motion_n;
			go_q         <= go_n;
			position_q   <= pos_n;
			direction_q  <= dir_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			level_s1 <= pwm_level;
			timer_s1 <= timer_value;
		end
		if (adv) begin
			duty_s2   <= duty_n;
			dir_s2    <= dir_n;
			motion_s2 <= motion_n;
			high_s2   <= high_n;
			pos_s2    <= pos_n;
		end
	end

	assign out_valid       = valid_s2;
	assign drive_duty      = duty_s2;
	assign direction       = dir_s2;
	assign motion_state    = motion_s2;
	assign pulse_high_time = high_s2;
	assign arm_position    = pos_s2;

	`PWAMC_ASSERT_NOW(a_duty_needs_motion, clk, arst_n,
		valid_s2 && duty_s2 != '0, motion_s2 != MOT_STOP, "duty driven while stopped")
	`PWAMC_ASSERT_NOW(a_up_dir, clk, arst_n,
		motion_q == MOT_UP, direction_q, "moving up with direction low")
	`PWAMC_ASSERT_NOW(a_down_dir, clk, arst_n,
		motion_q == MOT_DOWN, !direction_q, "moving down with direction high")
	`PWAMC_ASSERT_NEXT(a_pos_hold, clk, arst_n,
		!adv, $stable(position_q) && $stable(motion_q), "state moved without an item")
	`PWAMC_ASSERT_NEXT(a_pos_step, clk, arst_n,
		adv, position_q == $past(position_q) || position_q == $past(position_q) + 1'b1
		|| position_q == $past(position_q) - 1'b1, "position jumped")

endmodule

`default_nettype wire
